// ----- src/afrc_pkg.sv -----
// ----------------------------------------------------------------------------
// afrc_pkg
// Shared types and constants for the audio frame rate changer.
// ----------------------------------------------------------------------------
package afrc_pkg;

   localparam int SAMPLE_W       = 32;
   localparam int NUM_CH         = 2;
   localparam int DATA_W         = SAMPLE_W * NUM_CH;
   localparam int MAX_FACTOR_DEF = 64;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int FACTOR_W   = 7;
   localparam int CHAN_W     = 2;

   localparam logic [CSR_IDX_W-1:0] REG_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FACTOR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNELS = 2'd2;

   localparam logic MODE_SPEED_UP  = 1'b0;
   localparam logic MODE_SLOW_DOWN = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_STEP,
      ST_EMIT,
      ST_FINAL
   } afrc_state_type;

endpackage

// ----- src/audio_frame_rate_changer.sv -----
// ----------------------------------------------------------------------------
// audio_frame_rate_changer
// Frame dropper / linear interpolator for one- or two-channel audio frames.
// ----------------------------------------------------------------------------
// Speed-up mode passes every factor-th frame and drops the rest; a frame is
// accepted in ST_IDLE, and a passed one is handed to the output register from
// ST_FINAL. Slow-down mode puts factor-1 interpolated frames ahead of each
// frame but the first. The first frame, and any frame at factor 1, goes
// straight to ST_FINAL. Any other frame goes through one shared restoring
// divider (33 quotient bits, channel 0 then channel 1) that splits
// |cur - prev| into quotient and remainder by the factor, then through a
// step/emit loop that advances each interpolated value by that quotient with
// a remainder carry. A stalled result port holds the emit and final states.
// The input is not ready while a frame is being worked on; the output
// register lets the next frame come in while the last result still waits.
// ----------------------------------------------------------------------------
module audio_frame_rate_changer #(
   parameter int MAX_FACTOR = afrc_pkg::MAX_FACTOR_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // config write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [afrc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [afrc_pkg::CSR_DATA_W-1:0] csr_data,
   // input frames
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [afrc_pkg::DATA_W-1:0]     req_tdata,  // sample_ch0, sample_ch1
   // output frames
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [afrc_pkg::DATA_W-1:0]     rsp_tdata,  // out_ch0, out_ch1
   output logic                            rsp_tlast   // last_of_run
);
   import afrc_pkg::*;

   localparam int FW    = $clog2(MAX_FACTOR + 1);   // effective factor width
   localparam int PH_W  = $clog2(MAX_FACTOR);       // phase / step index width
   localparam int DVD_W = SAMPLE_W + 1;             // |cur - prev| width
   localparam int CNT_W = $clog2(DVD_W);

   // configuration
   logic                mode_ff, mode_in;
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic [CHAN_W-1:0]   chan_ff, chan_in;

   // frame state
   logic [PH_W-1:0]     phase_ff, phase_in;
   logic                seen_ff, seen_in;
   logic [SAMPLE_W-1:0] cur_ff [NUM_CH];
   logic [SAMPLE_W-1:0] cur_in [NUM_CH];
   logic [SAMPLE_W-1:0] prev_ff [NUM_CH];
   logic [SAMPLE_W-1:0] prev_in [NUM_CH];

   // divider
   logic [DVD_W-1:0]    dvd_ff, dvd_in;
   logic [FW-1:0]       rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                ch_ff, ch_in;

   // interpolation accumulators
   logic [DVD_W-1:0]    quo_ff [NUM_CH];
   logic [DVD_W-1:0]    quo_in [NUM_CH];
   logic [FW-1:0]       rmd_ff [NUM_CH];
   logic [FW-1:0]       rmd_in [NUM_CH];
   logic [DVD_W-1:0]    acc_ff [NUM_CH];
   logic [DVD_W-1:0]    acc_in [NUM_CH];
   logic [FW-1:0]       car_ff [NUM_CH];
   logic [FW-1:0]       car_in [NUM_CH];
   logic                neg_ff [NUM_CH];
   logic                neg_in [NUM_CH];
   logic [PH_W-1:0]     k_ff, k_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   afrc_state_type      state_ff, state_in;

   logic                f_over;
   logic [FW-1:0]       f_eff;
   logic                stereo;
   logic                req_acc;
   logic                out_free;
   logic                load_out;
   logic                div_last;
   logic                k_done;
   logic                pass;

   logic [DVD_W-1:0]    diff;
   logic [DVD_W-1:0]    mag;
   logic [FW:0]         div_t;
   logic                div_ge;
   logic [FW:0]         step_r [NUM_CH];
   logic [SAMPLE_W+1:0] interp [NUM_CH];

   // effective factor: zero acts as one, large values saturate
   assign f_over  = 32'(factor_ff) > 32'(MAX_FACTOR);
   assign f_eff   = f_over ? FW'(MAX_FACTOR) :
                    (factor_ff == '0) ? FW'(1) : FW'(factor_ff);
   assign stereo  = chan_ff[1];

   assign req_acc  = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign div_last = (cnt_ff == CNT_W'(DVD_W - 1));
   assign k_done   = (FW'(k_ff) == f_eff - FW'(1));
   assign pass     = (phase_ff == '0);

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (mode_ff == MODE_SLOW_DOWN) begin
                  state_in = (seen_ff && f_eff != FW'(1)) ? ST_DIV : ST_FINAL;
               end else begin
                  state_in = pass ? ST_FINAL : ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            // leave once channel one's quotient has been captured
            if (cnt_ff == CNT_W'(DVD_W) && ch_ff) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = k_done ? ST_FINAL : ST_STEP;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_EMIT:  load_out   = out_free;
         ST_FINAL: load_out   = out_free;
         default: begin
            req_tready = 1'b0;
            load_out   = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      mode_in      = mode_ff;
      factor_in    = factor_ff;
      chan_in      = chan_ff;
      phase_in     = phase_ff;
      seen_in      = seen_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      ch_in        = ch_ff;
      quo_in       = quo_ff;
      rmd_in       = rmd_ff;
      acc_in       = acc_ff;
      car_in       = car_ff;
      neg_in       = neg_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MODE:     mode_in   = csr_data[0];
            REG_FACTOR:   factor_in = csr_data[FACTOR_W-1:0];
            REG_CHANNELS: chan_in   = csr_data[CHAN_W-1:0];
            default:      mode_in   = mode_ff;
         endcase
      end

      // |cur - prev| of the channel being divided
      diff = {cur_ff[ch_ff][SAMPLE_W-1], cur_ff[ch_ff]}
           - {prev_ff[ch_ff][SAMPLE_W-1], prev_ff[ch_ff]};
      mag  = diff[DVD_W-1] ? (~diff + DVD_W'(1)) : diff;

      // one restoring division step
      div_t  = {rem_ff, dvd_ff[DVD_W-1]};
      div_ge = div_t >= {1'b0, f_eff};

      for (int c = 0; c < NUM_CH; c++) begin
         step_r[c] = {1'b0, car_ff[c]} + {1'b0, rmd_ff[c]};
         interp[c] = {{2{prev_ff[c][SAMPLE_W-1]}}, prev_ff[c]}
                   + (neg_ff[c] ? (~{1'b0, acc_ff[c]} + (SAMPLE_W+2)'(1))
                                : {1'b0, acc_ff[c]});
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               cur_in[0] = req_tdata[SAMPLE_W-1:0];
               cur_in[1] = stereo ? req_tdata[2*SAMPLE_W-1:SAMPLE_W] : '0;
               seen_in   = 1'b1;
               ch_in     = 1'b0;
               cnt_in    = '0;
               rem_in    = '0;
               k_in      = '0;
               for (int c = 0; c < NUM_CH; c++) begin
                  acc_in[c] = '0;
                  car_in[c] = '0;
               end
               if (mode_ff == MODE_SPEED_UP) begin
                  phase_in = (FW'(phase_ff) + FW'(1) >= f_eff) ? '0
                           : phase_ff + PH_W'(1);
               end
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               // first cycle of a channel: load the magnitude
               dvd_in = mag;
               neg_in[ch_ff] = diff[DVD_W-1];
               cnt_in = CNT_W'(1);
               rem_in = '0;
            end else begin
               rem_in = div_ge ? FW'(div_t - {1'b0, f_eff}) : FW'(div_t);
               dvd_in = {dvd_ff[DVD_W-2:0], div_ge};
               cnt_in = cnt_ff + CNT_W'(1);
            end
            // the last bit lands here; capture with this step folded in
            if (cnt_ff == CNT_W'(DVD_W)) begin
               cnt_in = '0;
            end
            if (div_last) begin
               cnt_in = CNT_W'(DVD_W);
            end
            if (cnt_ff == CNT_W'(DVD_W)) begin
               quo_in[ch_ff] = dvd_in;
               rmd_in[ch_ff] = rem_in;
               ch_in         = 1'b1;
               dvd_in        = dvd_ff;
            end
         end
         ST_STEP: begin
            for (int c = 0; c < NUM_CH; c++) begin
               if (step_r[c] >= {1'b0, f_eff}) begin
                  car_in[c] = FW'(step_r[c] - {1'b0, f_eff});
                  acc_in[c] = acc_ff[c] + quo_ff[c] + DVD_W'(1);
               end else begin
                  car_in[c] = FW'(step_r[c]);
                  acc_in[c] = acc_ff[c] + quo_ff[c];
               end
            end
            k_in = k_ff + PH_W'(1);
         end
         ST_EMIT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               rsp_data_in  = {stereo ? interp[1][SAMPLE_W-1:0] : '0,
                               interp[0][SAMPLE_W-1:0]};
            end
         end
         ST_FINAL: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_data_in  = {cur_ff[1], cur_ff[0]};
               if (mode_ff == MODE_SLOW_DOWN) begin
                  prev_in = cur_ff;
               end
            end
         end
         default: rsp_valid_in = rsp_valid_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_SPEED_UP;
         factor_ff    <= FACTOR_W'(1);
         chan_ff      <= CHAN_W'(1);
         phase_ff     <= '0;
         seen_ff      <= 1'b0;
         prev_ff[0]   <= '0;
         prev_ff[1]   <= '0;
         cnt_ff       <= '0;
         ch_ff        <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         factor_ff    <= factor_in;
         chan_ff      <= chan_in;
         phase_ff     <= phase_in;
         seen_ff      <= seen_in;
         prev_ff      <= prev_in;
         cnt_ff       <= cnt_in;
         ch_ff        <= ch_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rmd_ff      <= rmd_in;
      acc_ff      <= acc_in;
      car_ff      <= car_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // interpolation carries stay below the factor
   a_carry_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (car_ff[0] < f_eff && car_ff[1] < f_eff))
      else $error("interpolation carry out of range");

   // only slow-down mode produces results that are not last of their run
   a_mid_only_slow: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (mode_ff == MODE_SLOW_DOWN))
      else $error("interpolated frame in speed-up mode");

   // results are loaded only from the emit states
   a_load_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT || $past(state_ff) == ST_FINAL))
      else $error("result loaded outside emit");

   // divider leaves for the step loop only after channel one
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && $past(state_ff) == ST_DIV) |-> ch_ff)
      else $error("divider left before second channel");

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for audio_frame_rate_changer.
// Stimulus is a short directed pass over extreme samples and register corner
// values. It is followed by random register settings and random frames. Every
// accepted frame is run through a local model of the dropper/interpolator,
// which queues the frames it should produce. Each output item is then checked
// against the oldest frame in that queue. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;
   import afrc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 300;  // covers a full interpolation run
   localparam int RANDOM_ITEMS   = 270;
   localparam logic [SAMPLE_W-1:0] S_MAX = 32'h7fff_ffff;
   localparam logic [SAMPLE_W-1:0] S_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [SAMPLE_W-1:0] ch1;
      logic [SAMPLE_W-1:0] ch0;
   } frame_t;

   typedef struct {
      frame_t data;
      logic   last;
   } out_frame_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;
   logic                  rsp_tlast;

   frame_t     frames_pending[$];
   out_frame_t frames_due[$];

   int  frames_queued  = 0;
   int  frames_taken   = 0;
   int  err_count      = 0;
   int  quiet_cycles   = 0;
   int  req_gap        = 0;
   int  rsp_wait       = 0;
   bit  req_calm       = 1'b0;
   bit  rsp_calm       = 1'b0;
   bit  req_took       = 1'b0;
   bit  csr_took       = 1'b0;

   // local copy of the registers and the frame state
   logic                cfg_mode   = MODE_SPEED_UP;
   logic [FACTOR_W-1:0] cfg_factor = 7'd1;
   logic [CHAN_W-1:0]   cfg_chans  = 2'd1;
   longint              prev_ch0   = 0;
   longint              prev_ch1   = 0;
   int                  drop_phase = 0;
   bit                  have_frame = 1'b0;

   audio_frame_rate_changer u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR %s: got %h, expected %h", what, got, want);
      err_count++;
   endtask

   function automatic void queue_out_frame(longint a, longint b, logic last);
      out_frame_t o;
      o.data.ch0 = a[SAMPLE_W-1:0];
      o.data.ch1 = b[SAMPLE_W-1:0];
      o.last     = last;
      frames_due.push_back(o);
   endfunction

   // works out the frames that one accepted input frame should produce
   function automatic void rate_change_frame(frame_t in);
      int     f;
      bit     stereo;
      longint cur0;
      longint cur1;
      longint a;
      longint b;
      f = (cfg_factor == 0) ? 1 :
          (cfg_factor > MAX_FACTOR_DEF) ? MAX_FACTOR_DEF : int'(cfg_factor);
      stereo = cfg_chans >= 2;
      cur0 = longint'(signed'(in.ch0));
      cur1 = stereo ? longint'(signed'(in.ch1)) : 64'sd0;
      if (cfg_mode == MODE_SPEED_UP) begin
         if (drop_phase == 0)
            queue_out_frame(cur0, cur1, 1'b1);
         drop_phase = (drop_phase + 1 >= f) ? 0 : drop_phase + 1;
         have_frame = 1'b1;
      end else begin
         if (have_frame) begin
            for (int k = 1; k < f; k++) begin
               a = prev_ch0 + ((cur0 - prev_ch0) * k) / f;
               b = stereo ? prev_ch1 + ((cur1 - prev_ch1) * k) / f : 64'sd0;
               queue_out_frame(a, b, 1'b0);
            end
         end
         queue_out_frame(cur0, cur1, 1'b1);
         prev_ch0   = cur0;
         prev_ch1   = cur1;
         have_frame = 1'b1;
      end
   endfunction

   // input driver
   always @(negedge clock) begin
      if (!reset && !(req_tvalid && !req_took)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (frames_pending.size() > 0) begin
            req_tdata  <= frames_pending.pop_front();
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 15) == 0)
               req_calm = !req_calm;
            req_gap = req_calm ? 0 : $urandom_range(0, 8);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // output stall
   always @(negedge clock) begin
      if (rsp_wait > 0) begin
         rsp_tready <= 1'b0;
         rsp_wait--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      frame_t     got;
      out_frame_t want;
      req_took = 1'b0;
      csr_took = 1'b0;
      if (!reset) begin
         quiet_cycles++;
         if (csr_valid && csr_ready) begin
            csr_took     = 1'b1;
            quiet_cycles = 0;
            case (csr_index)
               REG_MODE:     cfg_mode   = csr_data[0];
               REG_FACTOR:   cfg_factor = csr_data[FACTOR_W-1:0];
               REG_CHANNELS: cfg_chans  = csr_data[CHAN_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            req_took     = 1'b1;
            quiet_cycles = 0;
            frames_taken++;
            rate_change_frame(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            quiet_cycles = 0;
            if ($urandom_range(0, 15) == 0)
               rsp_calm = !rsp_calm;
            rsp_wait = rsp_calm ? 0 : $urandom_range(0, 8);
            got = rsp_tdata;
            if (frames_due.size() == 0) begin
               report_mismatch("unexpected item, out_ch0", got.ch0, '0);
            end else begin
               want = frames_due.pop_front();
               if (got.ch0 !== want.data.ch0)
                  report_mismatch("out_ch0", got.ch0, want.data.ch0);
               if (got.ch1 !== want.data.ch1)
                  report_mismatch("out_ch1", got.ch1, want.data.ch1);
               if (rsp_tlast !== want.last)
                  report_mismatch("last_of_run", 32'(rsp_tlast), 32'(want.last));
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic push_frame(logic [SAMPLE_W-1:0] ch0, logic [SAMPLE_W-1:0] ch1);
      frame_t fr;
      fr.ch0 = ch0;
      fr.ch1 = ch1;
      frames_pending.push_back(fr);
      frames_queued++;
   endtask

   // returns at a falling edge once all frames are in and all results are out
   task automatic wait_idle();
      @(negedge clock);
      while (frames_taken != frames_queued || frames_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // called at a falling edge; leaves csr_valid high
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      @(negedge clock);
      while (!csr_took)
         @(negedge clock);
   endtask

   task automatic set_config(logic [CSR_DATA_W-1:0] m, logic [CSR_DATA_W-1:0] f,
                             logic [CSR_DATA_W-1:0] c);
      wait_idle();
      write_reg(REG_MODE, m);
      write_reg(REG_FACTOR, f);
      write_reg(REG_CHANNELS, c);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [SAMPLE_W-1:0] draw_sample(logic [SAMPLE_W-1:0] last);
      case ($urandom_range(0, 7))
         0:       return S_MIN;
         1:       return S_MAX;
         2:       return 32'($urandom_range(0, 2)) - 32'd1;
         3, 4:    return last + 32'($urandom_range(0, 200)) - 32'd100;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [SAMPLE_W-1:0] s0;
      logic [SAMPLE_W-1:0] s1;
      logic [CSR_DATA_W-1:0] fac;
      int n;
      int sent;
      s0   = '0;
      s1   = '0;
      sent = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // slow-down first, so the very first frame gets no interpolation
      set_config(CSR_DATA_W'(MODE_SLOW_DOWN), 7'd5, 7'd2);
      push_frame(S_MAX, S_MIN);
      push_frame(S_MIN, S_MAX);
      push_frame(32'd0, 32'hffff_ffff);
      // factor zero acts as one
      set_config(CSR_DATA_W'(MODE_SLOW_DOWN), 7'd0, 7'd2);
      push_frame(32'hffff_ffff, 32'd0);
      // factor above the cap, channel count three
      set_config(CSR_DATA_W'(MODE_SLOW_DOWN), 7'd127, 7'd3);
      push_frame(S_MAX, S_MIN);
      // channel count zero: mono, channel one ignored
      set_config(CSR_DATA_W'(MODE_SLOW_DOWN), 7'd7, 7'd0);
      push_frame(S_MIN, 32'h1234_5678);
      push_frame(32'd100, 32'hffff_fffb);
      set_config(CSR_DATA_W'(MODE_SPEED_UP), 7'd3, 7'd2);
      push_frame(S_MAX, S_MAX);
      push_frame(S_MIN, S_MIN);
      push_frame(32'h5555_aaaa, 32'haaaa_5555);
      push_frame(32'd1, 32'hffff_ffff);
      push_frame(32'hdead_beef, 32'h0bad_f00d);
      // lower the factor to no more than the current phase
      set_config(CSR_DATA_W'(MODE_SPEED_UP), 7'd2, 7'd2);
      push_frame(32'h0000_0007, 32'h7000_0000);
      push_frame(32'hffff_0000, 32'h0000_ffff);
      set_config(CSR_DATA_W'(MODE_SPEED_UP), 7'd1, 7'd1);
      push_frame(S_MAX, S_MAX);
      push_frame(S_MIN, S_MIN);
      // back to slow-down: previous frame is the last slow-down one
      set_config(CSR_DATA_W'(MODE_SLOW_DOWN), 7'd3, 7'd1);
      push_frame(32'h8000_0001, 32'h7fff_fffe);
      wait_idle();
      write_reg(REG_SPARE, 7'h7f);
      csr_valid <= 1'b0;
      push_frame(32'h0000_0010, 32'h0000_0020);

      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       fac = 7'd0;
            1:       fac = 7'd64;
            2:       fac = 7'($urandom_range(65, 127));
            3:       fac = 7'($urandom_range(9, 63));
            default: fac = 7'($urandom_range(1, 8));
         endcase
         // upper bits of mode and channel count are don't-care
         set_config(7'($urandom_range(0, 127)), fac, 7'($urandom_range(0, 127)));
         n = $urandom_range(4, 20);
         repeat (n) begin
            s0 = draw_sample(s0);
            s1 = draw_sample(s1);
            push_frame(s0, s1);
         end
         sent += n;
      end

      wait_idle();
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- sim.f -----
src/afrc_pkg.sv
src/audio_frame_rate_changer.sv
dv/tb.sv
